[rtl/bitmap_merge_with_collision_top_defines.svh]
// Assertion macros for the bitmap merge block and its port checker.
// Depends on nothing; included by the checker file only.
`ifndef BITMAP_MERGE_WITH_COLLISION_TOP_DEFINES_SVH
`define BITMAP_MERGE_WITH_COLLISION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMC_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bitmap merge check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define BMC_ASSERT_LAT(lbl, ck, rs, ante, n, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##n (cons)) \
    else $error("bitmap merge latency check failed");

`endif

[rtl/bmc_pkg.sv]
// Shared constants, status codes, stage control type and clamp functions
// for the bitmap merge block. Depends on nothing.
package bmc_pkg;

  localparam int MASK_BITS_DEF = 64;
  localparam int MAX_SIDE_DEF  = 8;
  localparam int OUT_BITS      = 64;

  localparam logic [1:0] ST_MERGED    = 2'd0;
  localparam logic [1:0] ST_OVERLAP   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       fits;
    logic [4:0] nw;
    logic [4:0] nh;
    logic [3:0] sx1;
    logic [3:0] sy1;
    logic [3:0] sx2;
    logic [3:0] sy2;
  } bmc_ctl_t;

  function automatic logic [3:0] clamp_side(input logic [3:0] v, input int max_side);
    logic [3:0] lim;
    lim = 4'(max_side);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic signed [4:0] clamp_offset(input logic signed [4:0] v,
                                                     input int max_side);
    logic signed [4:0] hi;
    logic signed [4:0] lo;
    hi = 5'(max_side);
    lo = 5'(-max_side);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

[rtl/bmc_unpack.sv]
// First stage: clamps sizes and offsets, forms the bounding box and shifts,
// and unpacks both grids onto fixed-stride planes. Depends on bmc_pkg.
module bmc_unpack #(
  parameter int MASK_BITS = 64,
  parameter int MAX_SIDE  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [3:0]                     first_width,
  input  logic [3:0]                     first_height,
  input  logic [63:0]                    first_bits,
  input  logic [3:0]                     second_width,
  input  logic [3:0]                     second_height,
  input  logic [63:0]                    second_bits,
  input  logic signed [4:0]              offset_x,
  input  logic signed [4:0]              offset_y,
  output bmc_pkg::bmc_ctl_t              ctl,
  output logic [MAX_SIDE*MAX_SIDE-1:0]   plane1,
  output logic [MAX_SIDE*MAX_SIDE-1:0]   plane2
);
  import bmc_pkg::*;

  logic [3:0]        w1, h1, w2, h2;
  logic signed [4:0] oxc, oyc;
  logic signed [6:0] ox, oy, minx, miny, ex, ey, maxx, maxy, nw, nh;
  logic signed [6:0] nminx, nminy, dx, dy;
  logic [9:0]        area;
  bmc_ctl_t          ctl_next;
  logic [MAX_SIDE*MAX_SIDE-1:0] p1_next, p2_next;

  assign w1  = clamp_side(first_width, MAX_SIDE);
  assign h1  = clamp_side(first_height, MAX_SIDE);
  assign w2  = clamp_side(second_width, MAX_SIDE);
  assign h2  = clamp_side(second_height, MAX_SIDE);
  assign oxc = clamp_offset(offset_x, MAX_SIDE);
  assign oyc = clamp_offset(offset_y, MAX_SIDE);

  always_comb begin
    ox    = {{2{oxc[4]}}, oxc};
    oy    = {{2{oyc[4]}}, oyc};
    minx  = (ox < 7'sd0) ? ox : 7'sd0;
    miny  = (oy < 7'sd0) ? oy : 7'sd0;
    ex    = ox + $signed({3'b000, w2});
    ey    = oy + $signed({3'b000, h2});
    maxx  = (ex > $signed({3'b000, w1})) ? ex : $signed({3'b000, w1});
    maxy  = (ey > $signed({3'b000, h1})) ? ey : $signed({3'b000, h1});
    nw    = maxx - minx;
    nh    = maxy - miny;
    nminx = -minx;
    nminy = -miny;
    dx    = ox - minx;
    dy    = oy - miny;
    area  = {5'b00000, nw[4:0]} * {5'b00000, nh[4:0]};
    ctl_next.valid = take;
    ctl_next.fits  = (area <= 10'(MASK_BITS));
    ctl_next.nw    = nw[4:0];
    ctl_next.nh    = nh[4:0];
    ctl_next.sx1   = nminx[3:0];
    ctl_next.sy1   = nminy[3:0];
    ctl_next.sx2   = dx[3:0];
    ctl_next.sy2   = dy[3:0];
  end

  for (genvar y = 0; y < MAX_SIDE; y++) begin : g_row
    for (genvar x = 0; x < MAX_SIDE; x++) begin : g_col
      logic [6:0] idx1, idx2;
      assign idx1 = 7'(y) * {3'b000, w1} + 7'(x);
      assign idx2 = 7'(y) * {3'b000, w2} + 7'(x);
      assign p1_next[y*MAX_SIDE+x] = (4'(x) < w1) && (4'(y) < h1) &&
                                     (idx1 < 7'(MASK_BITS)) && first_bits[idx1[5:0]];
      assign p2_next[y*MAX_SIDE+x] = (4'(x) < w2) && (4'(y) < h2) &&
                                     (idx2 < 7'(MASK_BITS)) && second_bits[idx2[5:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_next.valid;
    end
    ctl.fits <= ctl_next.fits;
    ctl.nw   <= ctl_next.nw;
    ctl.nh   <= ctl_next.nh;
    ctl.sx1  <= ctl_next.sx1;
    ctl.sy1  <= ctl_next.sy1;
    ctl.sx2  <= ctl_next.sx2;
    ctl.sy2  <= ctl_next.sy2;
    plane1   <= p1_next;
    plane2   <= p2_next;
  end

endmodule

[rtl/bmc_place.sv]
// Second stage: moves both planes into bounding-box coordinates, ORs them
// row by row and marks rows where both grids set a cell. Depends on bmc_pkg.
module bmc_place #(
  parameter int MAX_SIDE = 8,
  parameter int BOX      = 2 * MAX_SIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmc_pkg::bmc_ctl_t             ctl_in,
  input  logic [MAX_SIDE*MAX_SIDE-1:0]  plane1,
  input  logic [MAX_SIDE*MAX_SIDE-1:0]  plane2,
  output bmc_pkg::bmc_ctl_t             ctl_out,
  output logic [BOX*BOX-1:0]            box_bits,
  output logic [BOX-1:0]                hit_rows
);
  import bmc_pkg::*;

  logic [BOX*BOX-1:0] box_next;
  logic [BOX-1:0]     hit_next;

  for (genvar r = 0; r < BOX; r++) begin : g_box_row
    logic [MAX_SIDE-1:0] row1, row2;
    logic [BOX-1:0]      put1, put2;

    always_comb begin
      row1 = '0;
      row2 = '0;
      for (int k = 0; k < MAX_SIDE; k++) begin
        if ({1'b0, ctl_in.sy1} + 5'(k) == 5'(r)) begin
          row1 = plane1[k*MAX_SIDE +: MAX_SIDE];
        end
        if ({1'b0, ctl_in.sy2} + 5'(k) == 5'(r)) begin
          row2 = plane2[k*MAX_SIDE +: MAX_SIDE];
        end
      end
      put1 = BOX'(row1) << ctl_in.sx1;
      put2 = BOX'(row2) << ctl_in.sx2;
    end

    assign box_next[r*BOX +: BOX] = put1 | put2;
    assign hit_next[r]            = |(put1 & put2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.fits <= ctl_in.fits;
    ctl_out.nw   <= ctl_in.nw;
    ctl_out.nh   <= ctl_in.nh;
    ctl_out.sx1  <= ctl_in.sx1;
    ctl_out.sy1  <= ctl_in.sy1;
    ctl_out.sx2  <= ctl_in.sx2;
    ctl_out.sy2  <= ctl_in.sy2;
    box_bits     <= box_next;
    hit_rows     <= hit_next;
  end

endmodule

[rtl/bmc_pack.sv]
// Third stage: packs box rows to the merged row stride, applies the overlap
// and area rules and registers the result beat. Depends on bmc_pkg.
module bmc_pack #(
  parameter int MAX_SIDE = 8,
  parameter int BOX      = 2 * MAX_SIDE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bmc_pkg::bmc_ctl_t         ctl,
  input  logic [BOX*BOX-1:0]        box_bits,
  input  logic [BOX-1:0]            hit_rows,
  output logic                      done,
  output logic [1:0]                status,
  output logic [4:0]                merged_width,
  output logic [4:0]                merged_height,
  output logic [63:0]               merged_bits,
  output logic [3:0]                first_shift_x,
  output logic [3:0]                first_shift_y,
  output logic [3:0]                second_shift_x,
  output logic [3:0]                second_shift_y
);
  import bmc_pkg::*;

  logic                overlap;
  logic [OUT_BITS-1:0] packed_bits;

  always_comb begin
    packed_bits = '0;
    for (int r = 0; r < BOX; r++) begin
      packed_bits = packed_bits |
                    (OUT_BITS'(box_bits[r*BOX +: BOX]) << (9'(r) * {4'b0000, ctl.nw}));
    end
    overlap = |hit_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    if (overlap) begin
      status         <= ST_OVERLAP;
      merged_width   <= '0;
      merged_height  <= '0;
      merged_bits    <= '0;
      first_shift_x  <= '0;
      first_shift_y  <= '0;
      second_shift_x <= '0;
      second_shift_y <= '0;
    end else begin
      status         <= ctl.fits ? ST_MERGED : ST_TOO_LARGE;
      merged_width   <= ctl.nw;
      merged_height  <= ctl.nh;
      merged_bits    <= ctl.fits ? packed_bits : '0;
      first_shift_x  <= ctl.sx1;
      first_shift_y  <= ctl.sy1;
      second_shift_x <= ctl.sx2;
      second_shift_y <= ctl.sy2;
    end
  end

endmodule

[rtl/bitmap_merge_with_collision_top.sv]
// Top level of the bitmap merge block: three pipeline stages, unpack,
// place and pack. Depends on bmc_pkg, bmc_unpack, bmc_place and bmc_pack.
//
// Usage: one grid pair is taken in every clock cycle in which start is high;
// busy is never raised, so back-to-back beats are always accepted. Each
// accepted beat yields exactly one result beat, marked by done, once it has
// passed the unpack, place and pack registers, in the order the beats were
// taken. The result is shown for one cycle only and cannot be held off, so
// the receiver must take it when done is high. The three register stages
// unpack the grids onto fixed-stride planes, move them into the bounding
// box, and pack the box rows to the merged stride. There is no state beyond
// the pipeline, and reset only clears the stage valid bits.
module bitmap_merge_with_collision_top #(
  parameter int MASK_BITS = bmc_pkg::MASK_BITS_DEF,
  parameter int MAX_SIDE  = bmc_pkg::MAX_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        first_width,
  input  logic [3:0]        first_height,
  input  logic [63:0]       first_bits,
  input  logic [3:0]        second_width,
  input  logic [3:0]        second_height,
  input  logic [63:0]       second_bits,
  input  logic signed [4:0] offset_x,
  input  logic signed [4:0] offset_y,
  output logic              done,
  output logic [1:0]        status,
  output logic [4:0]        merged_width,
  output logic [4:0]        merged_height,
  output logic [63:0]       merged_bits,
  output logic [3:0]        first_shift_x,
  output logic [3:0]        first_shift_y,
  output logic [3:0]        second_shift_x,
  output logic [3:0]        second_shift_y
);
  import bmc_pkg::*;

  localparam int BOX = 2 * MAX_SIDE;

  logic                         take;
  bmc_ctl_t                     ctl1, ctl2;
  logic [MAX_SIDE*MAX_SIDE-1:0] plane1, plane2;
  logic [BOX*BOX-1:0]           box_bits;
  logic [BOX-1:0]               hit_rows;

  assign busy = 1'b0;
  assign take = start && !busy;

  bmc_unpack #(
    .MASK_BITS (MASK_BITS),
    .MAX_SIDE  (MAX_SIDE)
  ) u_unpack (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .first_width   (first_width),
    .first_height  (first_height),
    .first_bits    (first_bits),
    .second_width  (second_width),
    .second_height (second_height),
    .second_bits   (second_bits),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .ctl           (ctl1),
    .plane1        (plane1),
    .plane2        (plane2)
  );

  bmc_place #(
    .MAX_SIDE (MAX_SIDE),
    .BOX      (BOX)
  ) u_place (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl1),
    .plane1   (plane1),
    .plane2   (plane2),
    .ctl_out  (ctl2),
    .box_bits (box_bits),
    .hit_rows (hit_rows)
  );

  bmc_pack #(
    .MAX_SIDE (MAX_SIDE),
    .BOX      (BOX)
  ) u_pack (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl2),
    .box_bits       (box_bits),
    .hit_rows       (hit_rows),
    .done           (done),
    .status         (status),
    .merged_width   (merged_width),
    .merged_height  (merged_height),
    .merged_bits    (merged_bits),
    .first_shift_x  (first_shift_x),
    .first_shift_y  (first_shift_y),
    .second_shift_x (second_shift_x),
    .second_shift_y (second_shift_y)
  );

endmodule

[rtl/bmc_checker.sv]
// Port-level checker for the bitmap merge block and its bind to the top.
// Depends on bmc_pkg and bitmap_merge_with_collision_top_defines.svh.
`include "bitmap_merge_with_collision_top_defines.svh"

module bmc_checker #(
  parameter int MASK_BITS = bmc_pkg::MASK_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [4:0]  merged_width,
  input logic [4:0]  merged_height,
  input logic [63:0] merged_bits,
  input logic [3:0]  first_shift_x,
  input logic [3:0]  first_shift_y,
  input logic [3:0]  second_shift_x,
  input logic [3:0]  second_shift_y
);
  import bmc_pkg::*;

  logic [9:0] area;
  logic       area_fits;
  logic       zero_fields;

  assign area        = {5'b00000, merged_width} * {5'b00000, merged_height};
  assign area_fits   = (area <= 10'(MASK_BITS));
  assign zero_fields = (merged_width == 5'd0) && (merged_height == 5'd0) &&
                       (merged_bits == 64'd0) &&
                       (first_shift_x == 4'd0) && (first_shift_y == 4'd0) &&
                       (second_shift_x == 4'd0) && (second_shift_y == 4'd0);

  `BMC_ASSERT_LAT(a_beat_latency, clk, rst, start && !busy, 3, done)
  `BMC_ASSERT_NOW(a_beat_source, clk, rst, done, $past(start && !busy, 3))
  `BMC_ASSERT_NOW(a_overlap_clear, clk, rst, done && status == ST_OVERLAP, zero_fields)
  `BMC_ASSERT_NOW(a_merged_fits, clk, rst, done && status == ST_MERGED, area_fits)
  `BMC_ASSERT_NOW(a_large_empty, clk, rst, done && status == ST_TOO_LARGE, !area_fits)

endmodule

bind bitmap_merge_with_collision_top bmc_checker #(
  .MASK_BITS (MASK_BITS)
) u_bmc_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .merged_width   (merged_width),
  .merged_height  (merged_height),
  .merged_bits    (merged_bits),
  .first_shift_x  (first_shift_x),
  .first_shift_y  (first_shift_y),
  .second_shift_x (second_shift_x),
  .second_shift_y (second_shift_y)
);

[verif/tb_bitmap_merge_with_collision_top.sv]
`timescale 1ns / 100ps
// Testbench for the bitmap merge block: sends grid pairs through the start/busy handshake
// and checks every done beat against a local merge predictor, field by field.
// Depends on bmc_pkg and bitmap_merge_with_collision_top.
module tb_bitmap_merge_with_collision_top;
  import bmc_pkg::*;

  typedef struct {
    logic [3:0]        fw;
    logic [3:0]        fh;
    logic [63:0]       fb;
    logic [3:0]        sw;
    logic [3:0]        sh;
    logic [63:0]       sb;
    logic signed [4:0] ox;
    logic signed [4:0] oy;
  } grid_pair_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  mw;
    logic [4:0]  mh;
    logic [63:0] mb;
    logic [3:0]  fsx;
    logic [3:0]  fsy;
    logic [3:0]  ssx;
    logic [3:0]  ssy;
  } merge_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [3:0]        first_width;
  logic [3:0]        first_height;
  logic [63:0]       first_bits;
  logic [3:0]        second_width;
  logic [3:0]        second_height;
  logic [63:0]       second_bits;
  logic signed [4:0] offset_x;
  logic signed [4:0] offset_y;
  logic              done;
  logic [1:0]        status;
  logic [4:0]        merged_width;
  logic [4:0]        merged_height;
  logic [63:0]       merged_bits;
  logic [3:0]        first_shift_x;
  logic [3:0]        first_shift_y;
  logic [3:0]        second_shift_x;
  logic [3:0]        second_shift_y;

  merge_result_t pending_merges[$];
  merge_result_t want;
  int            error_count = 0;

  bitmap_merge_with_collision_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_width(first_width),
    .first_height(first_height),
    .first_bits(first_bits),
    .second_width(second_width),
    .second_height(second_height),
    .second_bits(second_bits),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .done(done),
    .status(status),
    .merged_width(merged_width),
    .merged_height(merged_height),
    .merged_bits(merged_bits),
    .first_shift_x(first_shift_x),
    .first_shift_y(first_shift_y),
    .second_shift_x(second_shift_x),
    .second_shift_y(second_shift_y)
  );

  always #5 clk = ~clk;

  function automatic int limit_side(input logic [3:0] v);
    return (v > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(v);
  endfunction

  function automatic int limit_offset(input logic signed [4:0] v);
    int s;
    s = int'(v);
    if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
    if (s < -MAX_SIDE_DEF) s = -MAX_SIDE_DEF;
    return s;
  endfunction

  function automatic bit grid_cell(input logic [63:0] cells, input int w, h, x, y);
    int idx;
    if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
    idx = y * w + x;
    if (idx >= MASK_BITS_DEF) return 1'b0;
    return cells[idx];
  endfunction

  function automatic merge_result_t merge_grids(input grid_pair_t p);
    merge_result_t r;
    int w1, h1, w2, h2, ox, oy;
    int minx, miny, maxx, maxy, nw, nh, x, y, idx;
    bit fits, c1, c2;
    logic [63:0] cells;
    r = '{default: '0};
    w1 = limit_side(p.fw);
    h1 = limit_side(p.fh);
    w2 = limit_side(p.sw);
    h2 = limit_side(p.sh);
    ox = limit_offset(p.ox);
    oy = limit_offset(p.oy);
    minx = (ox < 0) ? ox : 0;
    miny = (oy < 0) ? oy : 0;
    maxx = (ox + w2 > w1) ? ox + w2 : w1;
    maxy = (oy + h2 > h1) ? oy + h2 : h1;
    nw = maxx - minx;
    nh = maxy - miny;
    fits = (nw * nh <= MASK_BITS_DEF);
    cells = '0;
    for (y = miny; y < maxy; y++) begin
      for (x = minx; x < maxx; x++) begin
        c1 = grid_cell(p.fb, w1, h1, x, y);
        c2 = grid_cell(p.sb, w2, h2, x - ox, y - oy);
        if (c1 && c2) begin
          r.status = ST_OVERLAP;
          return r;
        end
        if ((c1 || c2) && fits) begin
          idx = (y - miny) * nw + (x - minx);
          if (idx < 64) cells[idx] = 1'b1;
        end
      end
    end
    r.status = fits ? ST_MERGED : ST_TOO_LARGE;
    r.mw = 5'(nw);
    r.mh = 5'(nh);
    r.mb = fits ? cells : '0;
    r.fsx = 4'(-minx);
    r.fsy = 4'(-miny);
    r.ssx = 4'(ox - minx);
    r.ssy = 4'(oy - miny);
    return r;
  endfunction

  function automatic grid_pair_t make_pair(input int fw, fh, input logic [63:0] fb,
                                           input int sw, sh, input logic [63:0] sb,
                                           input int ox, oy);
    grid_pair_t p;
    p.fw = 4'(fw);
    p.fh = 4'(fh);
    p.fb = fb;
    p.sw = 4'(sw);
    p.sh = 4'(sh);
    p.sb = sb;
    p.ox = 5'(ox);
    p.oy = 5'(oy);
    return p;
  endfunction

  function automatic logic [63:0] random_cells();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return '1;
    repeat ($urandom_range(0, 3)) v &= {$urandom, $urandom};
    return v;
  endfunction

  function automatic logic [3:0] random_side();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(0, MAX_SIDE_DEF));
  endfunction

  function automatic logic signed [4:0] random_offset();
    if ($urandom_range(0, 7) == 0) return 5'($urandom);
    return 5'(int'($urandom_range(0, 2 * MAX_SIDE_DEF)) - MAX_SIDE_DEF);
  endfunction

  // Most pairs are steered away from a collision so the merge path gets real traffic.
  function automatic grid_pair_t random_pair();
    grid_pair_t p;
    merge_result_t r;
    int tries;
    p.fw = random_side();
    p.fh = random_side();
    p.fb = random_cells();
    p.sw = random_side();
    p.sh = random_side();
    p.sb = random_cells();
    p.ox = random_offset();
    p.oy = random_offset();
    if ($urandom_range(0, 9) < 7) begin
      r = merge_grids(p);
      tries = 0;
      while (r.status == ST_OVERLAP && tries < 4) begin
        if (tries[0]) p.fb &= {$urandom, $urandom};
        else p.sb &= {$urandom, $urandom};
        r = merge_grids(p);
        tries++;
      end
      if (r.status == ST_OVERLAP) p.sb = '0;
    end
    return p;
  endfunction

  task automatic send_pair(input grid_pair_t p);
    logic held;
    first_width <= p.fw;
    first_height <= p.fh;
    first_bits <= p.fb;
    second_width <= p.sw;
    second_height <= p.sh;
    second_bits <= p.sb;
    offset_x <= p.ox;
    offset_y <= p.oy;
    start <= 1'b1;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
    pending_merges.push_back(merge_grids(p));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_merges.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_pair(make_pair(0, 0, '0, 0, 0, '0, 0, 0));
    send_pair(make_pair(0, 0, '1, 0, 0, '1, 0, 0));
    send_pair(make_pair(2, 2, '1, 0, 3, '1, 5, -4));
    send_pair(make_pair(8, 8, '1, 8, 8, '1, 8, 0));
    send_pair(make_pair(8, 8, '1, 8, 8, '1, 7, 7));
    send_pair(make_pair(3, 3, 64'h1ff, 2, 2, 64'hf, 1, 1));
    send_pair(make_pair(8, 4, '1, 8, 4, '1, 0, 4));
    send_pair(make_pair(4, 4, 64'h8421, 4, 4, 64'h1248, -4, -4));
    send_pair(make_pair(4, 4, 64'h8421, 4, 4, 64'h1248, -8, -8));
    send_pair(make_pair(15, 15, '1, 9, 12, '0, 0, 0));
    send_pair(make_pair(15, 9, 64'h0f0f, 12, 15, 64'hf0f0_0000, 2, 3));
    send_pair(make_pair(1, 1, 64'h1, 1, 1, 64'h1, -16, 15));
    send_pair(make_pair(1, 1, 64'h1, 1, 1, 64'h1, 15, -16));
    send_pair(make_pair(3, 2, 64'hffff_ffff_ffff_ffd5, 2, 3, 64'hffff_ffff_ffff_ffea, 3, 0));
    send_pair(make_pair(7, 1, 64'h7f, 1, 7, '1, -1, 1));
    send_pair(make_pair(8, 8, 64'h8000_0000_0000_0000, 8, 8, 64'h1, 7, 7));
    send_pair(make_pair(4, 4, '1, 4, 4, '1, 4, 0));
    send_pair(make_pair(8, 8, 64'h5555_5555_5555_5555, 2, 2, 64'ha, 2, 2));
    send_pair(make_pair(8, 8, 64'h5555_5555_5555_5555, 2, 2, 64'h5, 2, 2));
    send_pair(make_pair(0, 8, '1, 8, 0, '1, -8, 8));
  endtask

  task automatic test_random_with_gaps(input int count);
    bit gappy;
    gappy = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) gappy = ($urandom_range(0, 2) != 0);
      if (gappy && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 13));
      send_pair(random_pair());
    end
  endtask

  task automatic test_drain_between_bursts();
    repeat (2) begin
      repeat (15) send_pair(random_pair());
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  function void compare_field(input string label, input logic [63:0] expected_value,
                              input logic [63:0] actual_value);
    if (actual_value !== expected_value) begin
      error_count++;
      $display("%0t: %s expected %h actual %h", $time, label, expected_value, actual_value);
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && done) begin
      if (pending_merges.size() == 0) begin
        error_count++;
        $display("%0t: result beat with no pending merge, expected none actual status %h",
                 $time, status);
      end else begin
        want = pending_merges.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("merged_width", 64'(want.mw), 64'(merged_width));
        compare_field("merged_height", 64'(want.mh), 64'(merged_height));
        compare_field("merged_bits", want.mb, merged_bits);
        compare_field("first_shift_x", 64'(want.fsx), 64'(first_shift_x));
        compare_field("first_shift_y", 64'(want.fsy), 64'(first_shift_y));
        compare_field("second_shift_x", 64'(want.ssx), 64'(second_shift_x));
        compare_field("second_shift_y", 64'(want.ssy), 64'(second_shift_y));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    first_width <= '0;
    first_height <= '0;
    first_bits <= '0;
    second_width <= '0;
    second_height <= '0;
    second_bits <= '0;
    offset_x <= '0;
    offset_y <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_with_gaps(400);
    test_drain_between_bursts();
    test_back_to_back(160);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
